>>> sv/lssl_pkg.sv
package lssl_pkg;

  localparam int unsigned CELL_W  = 7;
  localparam int unsigned DIM_W   = 8;
  localparam int unsigned PHI_W   = 32;
  localparam int unsigned SP_W    = 31;
  localparam int unsigned CTR_W   = 40;
  localparam int unsigned NUM_W   = 62;
  localparam int unsigned POS_W   = 64;
  localparam int unsigned DIV_STEPS = NUM_W / 2;
  localparam int unsigned CNT_W   = $clog2(DIV_STEPS);
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned S_TUSER_W = 3;
  localparam int unsigned M_TDATA_W = 72;
  localparam int unsigned M_TUSER_W = 2;

  typedef enum logic [1:0] {
    KIND_WRITE    = 2'd0,
    KIND_SURFACE  = 2'd1,
    KIND_POSITION = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_OUTSIDE      = 2'd1,
    ST_NOT_SURFACE  = 2'd2,
    ST_NO_NEIGHBOUR = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_SPACING_X   = 3'd2,
    REG_SPACING_Y   = 3'd3,
    REG_ORIGIN_X    = 3'd4,
    REG_ORIGIN_Y    = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    RD_CENTRE = 3'd0,
    RD_LEFT   = 3'd1,
    RD_RIGHT  = 3'd2,
    RD_DOWN   = 3'd3,
    RD_UP     = 3'd4
  } rd_sel_e;

  typedef struct packed {
    logic [DIM_W-1:0]        grid_width;
    logic [DIM_W-1:0]        grid_height;
    logic [SP_W-1:0]         spacing_x;
    logic [SP_W-1:0]         spacing_y;
    logic signed [PHI_W-1:0] origin_x;
    logic signed [PHI_W-1:0] origin_y;
  } cfg_t;

  typedef struct packed {
    logic    capture_in;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    cap_en;
    rd_sel_e cap_sel;
    logic    setup;
    logic    div_step;
    logic    pos_calc;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic inside_in;
    logic pos_ok;
    logic div_last;
    logic out_free;
  } dp_sts_t;

endpackage

>>> sv/lssl_ram.sv
module lssl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/lssl_regs.sv
module lssl_regs
  import lssl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width  <= DIM_W'(32);
      cfg_q.grid_height <= DIM_W'(32);
      cfg_q.spacing_x   <= SP_W'(65536);
      cfg_q.spacing_y   <= SP_W'(65536);
      cfg_q.origin_x    <= '0;
      cfg_q.origin_y    <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_GRID_WIDTH:  cfg_q.grid_width  <= pwdata[DIM_W-1:0];
        REG_GRID_HEIGHT: cfg_q.grid_height <= pwdata[DIM_W-1:0];
        REG_SPACING_X:   cfg_q.spacing_x   <= pwdata[SP_W-1:0];
        REG_SPACING_Y:   cfg_q.spacing_y   <= pwdata[SP_W-1:0];
        REG_ORIGIN_X:    cfg_q.origin_x    <= pwdata;
        REG_ORIGIN_Y:    cfg_q.origin_y    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_GRID_WIDTH:  prdata = PDATA_W'(cfg_q.grid_width);
      REG_GRID_HEIGHT: prdata = PDATA_W'(cfg_q.grid_height);
      REG_SPACING_X:   prdata = PDATA_W'(cfg_q.spacing_x);
      REG_SPACING_Y:   prdata = PDATA_W'(cfg_q.spacing_y);
      REG_ORIGIN_X:    prdata = cfg_q.origin_x;
      REG_ORIGIN_Y:    prdata = cfg_q.origin_y;
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/lssl_ctrl.sv
module lssl_ctrl
  import lssl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_kind_i,
  output logic       in_ready_o,
  input  dp_sts_t    sts_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_RD_C = 11'b000_0000_0010,
    S_RD_L = 11'b000_0000_0100,
    S_RD_R = 11'b000_0000_1000,
    S_RD_D = 11'b000_0001_0000,
    S_RD_U = 11'b000_0010_0000,
    S_EVAL = 11'b000_0100_0000,
    S_MUL  = 11'b000_1000_0000,
    S_DIV  = 11'b001_0000_0000,
    S_POS  = 11'b010_0000_0000,
    S_EMIT = 11'b100_0000_0000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] kind_q, kind_d;

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture_in = 1'b1;
          kind_d           = in_kind_i;
          if (in_kind_i == KIND_SURFACE || in_kind_i == KIND_POSITION) begin
            state_d = sts_i.inside_in ? S_RD_C : S_EMIT;
          end
        end
      end
      S_RD_C: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_CENTRE;
        state_d      = S_RD_L;
      end
      S_RD_L: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_LEFT;
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sel = RD_CENTRE;
        state_d       = S_RD_R;
      end
      S_RD_R: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_RIGHT;
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sel = RD_LEFT;
        state_d       = S_RD_D;
      end
      S_RD_D: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_DOWN;
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sel = RD_RIGHT;
        state_d       = S_RD_U;
      end
      S_RD_U: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_UP;
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sel = RD_DOWN;
        state_d       = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sel = RD_UP;
        state_d       = (kind_q == KIND_POSITION) ? S_MUL : S_EMIT;
      end
      S_MUL: begin
        cmd_o.setup = 1'b1;
        state_d     = sts_i.pos_ok ? S_DIV : S_EMIT;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_POS;
        end
      end
      S_POS: begin
        cmd_o.pos_calc = 1'b1;
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= KIND_WRITE;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

>>> sv/lssl_dp.sv
module lssl_dp
  import lssl_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  dp_cmd_t                 cmd_i,
  output dp_sts_t                 sts_o,
  input  logic [1:0]              in_kind_i,
  input  logic [CELL_W-1:0]       in_cell_x_i,
  input  logic [CELL_W-1:0]       in_cell_y_i,
  input  logic signed [PHI_W-1:0] in_phi_value_i,
  input  logic                    in_axis_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              out_status_o,
  output logic                    out_is_surface_o,
  output logic [1:0]              out_horizontal_hits_o,
  output logic [1:0]              out_vertical_hits_o,
  output logic signed [PHI_W-1:0] out_position_x_o,
  output logic signed [PHI_W-1:0] out_position_y_o
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam logic [AW-1:0] RowStride = AW'(MAX_WIDTH);

  function automatic logic [AW-1:0] cell_addr(input logic [DIM_W-1:0] cx,
                                              input logic [DIM_W-1:0] cy);
    return AW'(cy) * RowStride + AW'(cx);
  endfunction

  function automatic logic [PHI_W+NUM_W-1:0] div_pair(input logic [PHI_W-1:0] rem,
                                                      input logic [NUM_W-1:0] nq,
                                                      input logic [PHI_W-1:0] den);
    logic [PHI_W:0]   ext;
    logic [PHI_W-1:0] r;
    logic [NUM_W-1:0] q;
    r = rem;
    q = nq;
    for (int i = 0; i < 2; i++) begin
      ext = {r, q[NUM_W-1]};
      if (ext >= {1'b0, den}) begin
        ext = ext - {1'b0, den};
        q   = {q[NUM_W-2:0], 1'b1};
      end else begin
        q   = {q[NUM_W-2:0], 1'b0};
      end
      r = ext[PHI_W-1:0];
    end
    return {r, q};
  endfunction

  function automatic logic [PHI_W-1:0] sat32(input logic [POS_W-1:0] v);
    if (!v[POS_W-1] && (|v[POS_W-2:PHI_W-1])) begin
      return {1'b0, {(PHI_W-1){1'b1}}};
    end else if (v[POS_W-1] && !(&v[POS_W-2:PHI_W-1])) begin
      return {1'b1, {(PHI_W-1){1'b0}}};
    end
    return v[PHI_W-1:0];
  endfunction

  logic [DIM_W-1:0] w_eff, h_eff;

  always_comb begin
    if (cfg_i.grid_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(cfg_i.grid_width) > MAX_WIDTH) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg_i.grid_width;
    end
    if (cfg_i.grid_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(cfg_i.grid_height) > MAX_HEIGHT) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = cfg_i.grid_height;
    end
  end

  logic inside_in;
  assign inside_in = ({1'b0, in_cell_x_i} < w_eff) && ({1'b0, in_cell_y_i} < h_eff);

  // latched item
  logic [CELL_W-1:0] x_q, y_q;
  logic [1:0]        kind_q;
  logic              axis_q;
  logic              inside_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture_in) begin
      x_q      <= in_cell_x_i;
      y_q      <= in_cell_y_i;
      kind_q   <= in_kind_i;
      axis_q   <= in_axis_i;
      inside_q <= inside_in;
    end
  end

  // neighbour coordinates
  logic [DIM_W-1:0] x8, y8, xl, xr, yd, yu;
  logic             has_l, has_r, has_d, has_u;

  always_comb begin
    x8    = {1'b0, x_q};
    y8    = {1'b0, y_q};
    has_l = x_q != '0;
    has_r = (x8 + DIM_W'(1)) < w_eff;
    has_d = y_q != '0;
    has_u = (y8 + DIM_W'(1)) < h_eff;
    xl    = has_l ? x8 - DIM_W'(1) : x8;
    xr    = has_r ? x8 + DIM_W'(1) : x8;
    yd    = has_d ? y8 - DIM_W'(1) : y8;
    yu    = has_u ? y8 + DIM_W'(1) : y8;
  end

  logic [AW-1:0]    raddr, waddr;
  logic [PHI_W-1:0] rdata;
  logic             we;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_CENTRE: raddr = cell_addr(x8, y8);
      RD_LEFT:   raddr = cell_addr(xl, y8);
      RD_RIGHT:  raddr = cell_addr(xr, y8);
      RD_DOWN:   raddr = cell_addr(x8, yd);
      RD_UP:     raddr = cell_addr(x8, yu);
      default:   raddr = cell_addr(x8, y8);
    endcase
  end

  assign waddr = cell_addr({1'b0, in_cell_x_i}, {1'b0, in_cell_y_i});
  assign we    = cmd_i.capture_in && (in_kind_i == KIND_WRITE) && inside_in;

  lssl_ram #(
    .WIDTH (PHI_W),
    .DEPTH (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_phi_value_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic signed [PHI_W-1:0] phi_c_q, phi_l_q, phi_r_q, phi_d_q, phi_u_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      unique case (cmd_i.cap_sel)
        RD_CENTRE: phi_c_q <= rdata;
        RD_LEFT:   phi_l_q <= rdata;
        RD_RIGHT:  phi_r_q <= rdata;
        RD_DOWN:   phi_d_q <= rdata;
        RD_UP:     phi_u_q <= rdata;
        default: ;
      endcase
    end
  end

  // neighbour evaluation
  logic       phi_pos, hit_l, hit_r, hit_d, hit_u, surf, lower, upper;
  logic [1:0] hh, vh;
  status_e    status;

  always_comb begin
    phi_pos = !phi_c_q[PHI_W-1] && (phi_c_q != '0);
    hit_l   = has_l && !phi_l_q[PHI_W-1] && !phi_pos;
    hit_r   = has_r && !phi_r_q[PHI_W-1] && !phi_pos;
    hit_d   = has_d && !phi_d_q[PHI_W-1] && !phi_pos;
    hit_u   = has_u && !phi_u_q[PHI_W-1] && !phi_pos;
    hh      = {1'b0, hit_l} + {1'b0, hit_r};
    vh      = {1'b0, hit_d} + {1'b0, hit_u};
    surf    = hit_l | hit_r | hit_d | hit_u;
    lower   = axis_q ? hit_d : hit_l;
    upper   = axis_q ? hit_u : hit_r;
    priority if (!inside_q) begin
      status = ST_OUTSIDE;
    end else if (kind_q == KIND_SURFACE) begin
      status = ST_OK;
    end else if (!surf) begin
      status = ST_NOT_SURFACE;
    end else if (!(lower || upper)) begin
      status = ST_NO_NEIGHBOUR;
    end else begin
      status = ST_OK;
    end
  end

  // interpolation setup
  logic signed [PHI_W-1:0] nphi;
  logic [PHI_W:0]          diff, negphi;
  logic [SP_W-1:0]         sp;
  logic [PHI_W+SP_W-1:0]   prod;
  logic [DIM_W+SP_W-1:0]   mx, my;
  logic signed [CTR_W-1:0] cx, cy;

  always_comb begin
    if (axis_q) begin
      nphi = lower ? phi_d_q : phi_u_q;
      sp   = cfg_i.spacing_y;
    end else begin
      nphi = lower ? phi_l_q : phi_r_q;
      sp   = cfg_i.spacing_x;
    end
    diff   = {nphi[PHI_W-1], nphi} - {phi_c_q[PHI_W-1], phi_c_q};
    negphi = (PHI_W+1)'(0) - {phi_c_q[PHI_W-1], phi_c_q};
    prod   = {{SP_W{1'b0}}, negphi[PHI_W-1:0]} * {{PHI_W{1'b0}}, sp};
    mx     = {{SP_W{1'b0}}, x_q, 1'b1} * {{DIM_W{1'b0}}, cfg_i.spacing_x};
    my     = {{SP_W{1'b0}}, y_q, 1'b1} * {{DIM_W{1'b0}}, cfg_i.spacing_y};
    cx     = {{(CTR_W-PHI_W){cfg_i.origin_x[PHI_W-1]}}, cfg_i.origin_x}
           + {2'b00, mx[DIM_W+SP_W-1:1]};
    cy     = {{(CTR_W-PHI_W){cfg_i.origin_y[PHI_W-1]}}, cfg_i.origin_y}
           + {2'b00, my[DIM_W+SP_W-1:1]};
  end

  logic [PHI_W-1:0]        den_q;
  logic                    den_zero_q;
  logic                    lower_q;
  logic signed [CTR_W-1:0] cx_q, cy_q;
  logic [NUM_W-1:0]        nq_q;
  logic [PHI_W-1:0]        rem_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [PHI_W-1:0]        px_q, py_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      den_q      <= diff[PHI_W-1:0];
      den_zero_q <= diff[PHI_W-1:0] == '0;
      lower_q    <= lower;
      cx_q       <= cx;
      cy_q       <= cy;
      nq_q       <= prod[NUM_W-1:0];
      rem_q      <= '0;
    end else if (cmd_i.div_step) begin
      {rem_q, nq_q} <= div_pair(rem_q, nq_q, den_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.setup) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // final position
  logic [POS_W-1:0] off, bx, by, fx, fy;

  always_comb begin
    off = den_zero_q ? '0 : {2'b00, nq_q};
    bx  = {{(POS_W-CTR_W){cx_q[CTR_W-1]}}, cx_q};
    by  = {{(POS_W-CTR_W){cy_q[CTR_W-1]}}, cy_q};
    fx  = bx;
    fy  = by;
    if (axis_q) begin
      fy = lower_q ? by - off : by + off;
    end else begin
      fx = lower_q ? bx - off : bx + off;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_calc) begin
      px_q <= sat32(fx);
      py_q <= sat32(fy);
    end
  end

  // output register
  logic              out_valid_q;
  logic [1:0]        o_status_q, o_hh_q, o_vh_q;
  logic              o_surf_q;
  logic [PHI_W-1:0]  o_px_q, o_py_q;
  logic              pos_out;

  assign pos_out = inside_q && (kind_q == KIND_POSITION) && (status == ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      o_status_q <= status;
      o_surf_q   <= inside_q && surf;
      o_hh_q     <= inside_q ? hh : 2'd0;
      o_vh_q     <= inside_q ? vh : 2'd0;
      o_px_q     <= pos_out ? px_q : '0;
      o_py_q     <= pos_out ? py_q : '0;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_status_o          = o_status_q;
  assign out_is_surface_o      = o_surf_q;
  assign out_horizontal_hits_o = o_hh_q;
  assign out_vertical_hits_o   = o_vh_q;
  assign out_position_x_o      = o_px_q;
  assign out_position_y_o      = o_py_q;

  assign sts_o.inside_in = inside_in;
  assign sts_o.pos_ok    = (status == ST_OK);
  assign sts_o.div_last  = cnt_q == CNT_W'(DIV_STEPS - 1);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

>>> sv/levelset_surface_locator_top.sv
// Write transfers produce no result; the next item is taken at once.
// Surface query: the result follows five grid reads through one port (none for a cell outside the grid).
// Position query: the result also waits on the radix-4 restoring divider
// (62-bit quotient), which dominates. One item in flight at a time.
// Reset: registers return to 32, 32, 1.0, 1.0, 0, 0; grid memory is not cleared and
// each cell is undefined until written.
module levelset_surface_locator_top
  import lssl_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // cell_x, cell_y, phi_value, zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // kind, axis
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // is_surface, horizontal_hits, vertical_hits, position_x, position_y, zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // status
  output logic [M_TUSER_W-1:0] m_axis_tuser
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  logic                    is_surface;
  logic [1:0]              hh, vh;
  logic signed [PHI_W-1:0] px, py;

  lssl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lssl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser[1:0]),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lssl_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .in_kind_i             (s_axis_tuser[1:0]),
    .in_cell_x_i           (s_axis_tdata[CELL_W-1:0]),
    .in_cell_y_i           (s_axis_tdata[2*CELL_W-1:CELL_W]),
    .in_phi_value_i        (s_axis_tdata[2*CELL_W+PHI_W-1:2*CELL_W]),
    .in_axis_i             (s_axis_tuser[2]),
    .out_valid_o           (m_axis_tvalid),
    .out_ready_i           (m_axis_tready),
    .out_status_o          (m_axis_tuser),
    .out_is_surface_o      (is_surface),
    .out_horizontal_hits_o (hh),
    .out_vertical_hits_o   (vh),
    .out_position_x_o      (px),
    .out_position_y_o      (py)
  );

  assign m_axis_tdata = {3'b000, py, px, vh, hh, is_surface};

endmodule

>>> test/tb_levelset_surface_locator_top.sv
module tb_levelset_surface_locator_top;
  import lssl_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned GRID_MAX = 128;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_OPS = 190;
  localparam int unsigned NUM_PHASES = 9;

  typedef longint unsigned u64_t;

  typedef struct {
    logic [1:0]        kind;
    logic [CELL_W-1:0] x;
    logic [CELL_W-1:0] y;
    logic [PHI_W-1:0]  phi;
    logic              axis;
  } cell_op_t;

  typedef struct {
    status_e          status;
    logic             surf;
    logic [1:0]       hh;
    logic [1:0]       vh;
    logic [PHI_W-1:0] px;
    logic [PHI_W-1:0] py;
  } locate_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // cell_x, cell_y, phi_value, zero pad
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  // kind, axis
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // is_surface, horizontal_hits, vertical_hits, position_x, position_y, zero pad
  logic [M_TDATA_W-1:0] m_axis_tdata;
  // status
  logic [M_TUSER_W-1:0] m_axis_tuser;

  logic [DIM_W-1:0] cfg_w = 8'd32;
  logic [DIM_W-1:0] cfg_h = 8'd32;
  u64_t             cfg_spx = 65536;
  u64_t             cfg_spy = 65536;
  int               cfg_ox = 0;
  int               cfg_oy = 0;

  int          phi_mirror [GRID_MAX*GRID_MAX];
  bit          gen_written [GRID_MAX*GRID_MAX];
  cell_op_t    op_queue [$];
  locate_res_t due_results [$];
  cell_op_t    drv_op;
  int unsigned gen_count = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned query_cnt = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 150;
  int unsigned mismatches = 0;

  levelset_surface_locator_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    return (v > GRID_MAX) ? GRID_MAX : v;
  endfunction

  function automatic logic [PHI_W-1:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic longint cell_centre(input int org, input u64_t sp, input int i);
    u64_t span;
    span = (2 * u64_t'(i) + 1) * sp;
    return longint'(org) + longint'(span >> 1);
  endfunction

  function automatic void locate_cell(input cell_op_t op);
    int unsigned w, h;
    int          xi, yi, phi, nb;
    bit          hl, hr, hd, hu, lower, upper;
    u64_t        sp, num, den, off;
    longint      cx, cy;
    locate_res_t r;
    w = eff_dim(cfg_w);
    h = eff_dim(cfg_h);
    xi = op.x;
    yi = op.y;
    if (op.kind == KIND_WRITE) begin
      if (xi < w && yi < h) phi_mirror[yi*GRID_MAX+xi] = op.phi;
      return;
    end
    if (op.kind == KIND_UNUSED) return;
    r.status = ST_OK;
    r.surf = 1'b0;
    r.hh = '0;
    r.vh = '0;
    r.px = '0;
    r.py = '0;
    if (!(xi < w && yi < h)) begin
      r.status = ST_OUTSIDE;
      due_results.insert(due_results.size(), r);
      return;
    end
    phi = phi_mirror[yi*GRID_MAX+xi];
    hl = xi > 0 && phi_mirror[yi*GRID_MAX+xi-1] >= 0;
    hr = xi + 1 < w && phi_mirror[yi*GRID_MAX+xi+1] >= 0;
    hd = yi > 0 && phi_mirror[(yi-1)*GRID_MAX+xi] >= 0;
    hu = yi + 1 < h && phi_mirror[(yi+1)*GRID_MAX+xi] >= 0;
    if (phi > 0) {hl, hr, hd, hu} = '0;
    r.hh = {1'b0, hl} + {1'b0, hr};
    r.vh = {1'b0, hd} + {1'b0, hu};
    r.surf = hl | hr | hd | hu;
    if (op.kind == KIND_POSITION) begin
      lower = op.axis ? hd : hl;
      upper = op.axis ? hu : hr;
      if (!r.surf) begin
        r.status = ST_NOT_SURFACE;
      end else if (!lower && !upper) begin
        r.status = ST_NO_NEIGHBOUR;
      end else begin
        if (op.axis) nb = phi_mirror[(lower ? yi - 1 : yi + 1)*GRID_MAX + xi];
        else nb = phi_mirror[yi*GRID_MAX + (lower ? xi - 1 : xi + 1)];
        sp = op.axis ? cfg_spy : cfg_spx;
        den = u64_t'(longint'(nb) - longint'(phi));
        num = u64_t'(-longint'(phi)) * sp;
        off = (den != 0) ? num / den : 0;
        cx = cell_centre(cfg_ox, cfg_spx, xi);
        cy = cell_centre(cfg_oy, cfg_spy, yi);
        if (op.axis) cy = lower ? cy - longint'(off) : cy + longint'(off);
        else cx = lower ? cx - longint'(off) : cx + longint'(off);
        r.px = sat32(cx);
        r.py = sat32(cy);
      end
    end
    due_results.insert(due_results.size(), r);
  endfunction

  function automatic void check_field(input string name, input logic [PHI_W-1:0] want,
                                      input logic [PHI_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        locate_cell(drv_op);
        if (drv_op.kind == KIND_SURFACE || drv_op.kind == KIND_POSITION)
          query_cnt <= query_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
          drv_op = op_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {2'b00, drv_op.phi, drv_op.y, drv_op.x};
          s_axis_tuser <= {drv_op.axis, drv_op.kind};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : result_check
    locate_res_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with nothing due, status %h data %h", $time,
                   m_axis_tuser, m_axis_tdata);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, m_axis_tuser);
          check_field("is_surface", want.surf, m_axis_tdata[0]);
          check_field("horizontal_hits", want.hh, m_axis_tdata[2:1]);
          check_field("vertical_hits", want.vh, m_axis_tdata[4:3]);
          check_field("position_x", want.px, m_axis_tdata[36:5]);
          check_field("position_y", want.py, m_axis_tdata[68:37]);
        end
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  // hold off the result side for a long stretch so the block stalls its input
  always @(posedge clk_i) begin
    if (query_cnt == next_hold_at) begin
      hold_left <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + 500;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic apb_write(input reg_idx_e idx, input logic [PDATA_W-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_GRID_WIDTH:  cfg_w = val[7:0];
      REG_GRID_HEIGHT: cfg_h = val[7:0];
      REG_SPACING_X:   cfg_spx = u64_t'(val[30:0]);
      REG_SPACING_Y:   cfg_spy = u64_t'(val[30:0]);
      REG_ORIGIN_X:    cfg_ox = val;
      REG_ORIGIN_Y:    cfg_oy = val;
      default: ;
    endcase
  endtask

  task automatic set_grid(input logic [31:0] w, input logic [31:0] h, input logic [31:0] spx,
                          input logic [31:0] spy, input logic [31:0] ox, input logic [31:0] oy);
    apb_write(REG_GRID_WIDTH, w);
    apb_write(REG_GRID_HEIGHT, h);
    apb_write(REG_SPACING_X, spx);
    apb_write(REG_SPACING_Y, spy);
    apb_write(REG_ORIGIN_X, ox);
    apb_write(REG_ORIGIN_Y, oy);
  endtask

  function automatic logic [PHI_W-1:0] rand_phi();
    case ($urandom_range(9))
      0, 1, 2: return $urandom_range(6) - 3;
      3:       return '0;
      4: begin
        case ($urandom_range(3))
          0:       return 32'h80000000;
          1:       return 32'h7fffffff;
          2:       return 32'hffffffff;
          default: return 32'h00000001;
        endcase
      end
      5:       return $urandom_range(262144);
      6:       return 0 - $urandom_range(262144);
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_op(input logic [1:0] kind, input int x, input int y,
                                  input logic [PHI_W-1:0] phi, input logic axis);
    cell_op_t op;
    op.kind = kind;
    op.x = CELL_W'(x);
    op.y = CELL_W'(y);
    op.phi = phi;
    op.axis = axis;
    if (kind == KIND_WRITE && x < eff_dim(cfg_w) && y < eff_dim(cfg_h))
      gen_written[y*GRID_MAX+x] = 1'b1;
    op_queue.insert(op_queue.size(), op);
    gen_count++;
  endfunction

  // write any cell of the neighbourhood not yet holding a value, then query
  function automatic void query_cell(input int x, input int y, input logic [1:0] kind,
                                     input logic axis);
    int unsigned w, h;
    w = eff_dim(cfg_w);
    h = eff_dim(cfg_h);
    if (!gen_written[y*GRID_MAX+x]) push_op(KIND_WRITE, x, y, rand_phi(), 1'b0);
    if (x > 0 && !gen_written[y*GRID_MAX+x-1]) push_op(KIND_WRITE, x - 1, y, rand_phi(), 1'b1);
    if (x + 1 < w && !gen_written[y*GRID_MAX+x+1])
      push_op(KIND_WRITE, x + 1, y, rand_phi(), 1'b0);
    if (y > 0 && !gen_written[(y-1)*GRID_MAX+x]) push_op(KIND_WRITE, x, y - 1, rand_phi(), 1'b1);
    if (y + 1 < h && !gen_written[(y+1)*GRID_MAX+x])
      push_op(KIND_WRITE, x, y + 1, rand_phi(), 1'b0);
    push_op(kind, x, y, $urandom, axis);
  endfunction

  function automatic int pick_coord(input int unsigned dim, input int unsigned base);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return ($urandom_range(1) != 0) ? dim - 1 : 0;
    if (r < 30) begin
      if (dim < 2) return 0;
      return ($urandom_range(1) != 0) ? dim - 2 : 1;
    end
    return base + $urandom_range((dim < 6 ? dim : 6) - 1);
  endfunction

  task automatic random_ops(input int unsigned n);
    int unsigned w, h, bx, by, r;
    int          x, y;
    w = eff_dim(cfg_w);
    h = eff_dim(cfg_h);
    bx = $urandom_range(w - (w < 6 ? w : 6));
    by = $urandom_range(h - (h < 6 ? h : 6));
    while (gen_count < n) begin
      r = $urandom_range(99);
      x = pick_coord(w, bx);
      y = pick_coord(h, by);
      if (r < 3) begin
        push_op(KIND_UNUSED, $urandom_range(127), $urandom_range(127), $urandom,
                $urandom_range(1));
      end else if (r < 8) begin
        push_op(KIND_WRITE, $urandom_range(127), $urandom_range(127), rand_phi(),
                $urandom_range(1));
      end else if (r < 18) begin
        if (w < GRID_MAX) begin
          push_op($urandom_range(1) ? KIND_SURFACE : KIND_POSITION, $urandom_range(127, w),
                  $urandom_range(127), $urandom, $urandom_range(1));
        end else if (h < GRID_MAX) begin
          push_op($urandom_range(1) ? KIND_SURFACE : KIND_POSITION, $urandom_range(127),
                  $urandom_range(127, h), $urandom, $urandom_range(1));
        end else begin
          query_cell(x, y, KIND_SURFACE, $urandom_range(1));
        end
      end else if (r < 38) begin
        push_op(KIND_WRITE, x, y, rand_phi(), $urandom_range(1));
      end else begin
        query_cell(x, y, ($urandom_range(9) < 3) ? KIND_SURFACE : KIND_POSITION,
                   $urandom_range(1));
      end
    end
  endtask

  task automatic drain();
    while (op_queue.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph / 3)
        0: begin
          send_idle = 17;
          recv_idle = 50;
        end
        1: begin
          send_idle = 50;
          recv_idle = 17;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      case (ph)
        0: ;
        1: set_grid(0, 128, 1, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        2: set_grid(255, 0, 32'h7fffffff, 1, 32'h7fffffff, 32'h80000000);
        3: set_grid(4, 4, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
        4: set_grid(128, 128, 65536, 65536, 0, 0);
        default: set_grid($urandom_range(1, 12), $urandom_range(1, 12),
                          $urandom_range(1) ? $urandom_range(1, 1 << 20)
                                            : $urandom_range(1, 32'h7fffffff),
                          $urandom_range(1) ? $urandom_range(1, 1 << 20)
                                            : $urandom_range(1, 32'h7fffffff),
                          $urandom, $urandom);
      endcase
      @(negedge clk_i);
      gen_count = 0;
      if (ph == 0) begin
        push_op(KIND_WRITE, 0, 0, 32'h80000000, 1'b0);
        push_op(KIND_WRITE, 1, 0, 32'h7fffffff, 1'b1);
        push_op(KIND_WRITE, 0, 1, 32'h00000000, 1'b0);
        push_op(KIND_SURFACE, 0, 0, 32'hffffffff, 1'b1);
        push_op(KIND_POSITION, 0, 0, 32'h00000000, 1'b0);
        push_op(KIND_POSITION, 0, 0, 32'hffffffff, 1'b1);
        push_op(KIND_WRITE, 31, 31, 32'h00000000, 1'b0);
        push_op(KIND_WRITE, 30, 31, 32'h00000000, 1'b0);
        push_op(KIND_WRITE, 31, 30, 32'hfffffffb, 1'b0);
        push_op(KIND_POSITION, 31, 31, 32'h12345678, 1'b0);
        push_op(KIND_POSITION, 31, 31, 32'h00000000, 1'b1);
        push_op(KIND_SURFACE, 127, 127, 32'h00000000, 1'b0);
        push_op(KIND_POSITION, 32, 5, 32'h00000000, 1'b0);
        push_op(KIND_WRITE, 32, 0, 32'h00000000, 1'b0);
        push_op(KIND_UNUSED, 5, 5, 32'hffffffff, 1'b1);
        push_op(KIND_WRITE, 2, 0, 32'h00000001, 1'b0);
        push_op(KIND_WRITE, 1, 1, 32'hffffffff, 1'b0);
        push_op(KIND_POSITION, 1, 0, 32'h00000000, 1'b0);
        push_op(KIND_SURFACE, 1, 0, 32'h00000000, 1'b1);
      end
      random_ops(PHASE_OPS);
      drain();
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(10 * 1500000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
